FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the anchor finder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UAF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/uaf_pkg.sv
// ----------------------------------------------------------------------------
// Anchor finder package
// Word types, anchor snapshot type and fixed sizes shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uaf_pkg;

   // Fixed field widths.
   localparam int POS_W      = 32;
   localparam int LANE_LIMIT = 16;
   localparam int LANE_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int GAP_W      = 16;

   // Anchor queue depth, a power of two so that the pointers wrap on their own.
   localparam int ANCHOR_DEPTH = 2;
   localparam int APTR_W       = 1;

   // Operation codes of an input word.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_COLUMN = 1'b1;

   // Minimum run length after reset.
   localparam logic [POS_W-1:0] MIN_LEN_RESET = 32'd100;

   typedef struct packed {
      logic               op;
      logic [LANE_W-1:0]  comp_index;
      logic [POS_W-1:0]   start_pos;
      logic [COUNT_W-1:0] comp_count;
      logic [GAP_W-1:0]   gap_mask;
      logic               last_column;
   } uaf_req_type;

   typedef struct packed {
      logic [LANE_W-1:0] anchor_comp;
      logic [POS_W-1:0]  anchor_start;
      logic [POS_W-1:0]  anchor_len;
      logic              last;
   } uaf_rsp_type;

   // One anchor as seen at the column that closed it: end positions per lane.
   typedef struct packed {
      logic [COUNT_W-1:0]                count;
      logic [POS_W-1:0]                  len;
      logic [LANE_LIMIT-1:0][POS_W-1:0] pos;
   } uaf_anchor_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } uaf_qstat_type;

endpackage

FILE: sv/ungapped_anchor_finder_core.sv
// The core takes one word per cycle: load words set a component's start and
// columns advance positions and the run counter, so push is refused only while
// both anchor slots of the internal queue are occupied. Each anchor found is
// delivered as one result word per active component, that is comp_count limited
// to MAX_COMPS and to 16, one word per cycle while the output is free or being
// popped, set by the back end's lane counter. The first word of an anchor goes
// through the queue and then the back end's output register before it can be
// popped. A second anchor can wait in the queue while the first drains. min_len
// is at byte address 0 of the register port.
// ----------------------------------------------------------------------------
// Ungapped anchor finder core
// Finds gap-free column runs of a multiple alignment and reports anchors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ungapped_anchor_finder_core #(
   parameter int MAX_COMPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  uaf_pkg::uaf_req_type          req_item,
   output logic                          empty,
   input  logic                          pop,
   output uaf_pkg::uaf_rsp_type          rsp_item,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import uaf_pkg::*;

   logic [POS_W-1:0] min_len_ff, min_len_in;
   logic             anchor_push, q_pop, csr_write;
   uaf_anchor_type   anchor_wr, anchor_rd;
   uaf_qstat_type    qstat;

   // Register port: one register, min_len, at word zero.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && !paddr[2];
   assign min_len_in = csr_write ? pwdata : min_len_ff;
   assign prdata    = paddr[2] ? '0 : min_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LEN_RESET;
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   uaf_front #(
      .MAX_COMPS (MAX_COMPS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_item    (req_item),
      .req_full    (full),
      .min_len     (min_len_ff),
      .qstat       (qstat),
      .anchor_push (anchor_push),
      .anchor      (anchor_wr)
   );

   uaf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (anchor_push),
      .wr_data (anchor_wr),
      .pop     (q_pop),
      .rd_data (anchor_rd),
      .qstat   (qstat)
   );

   uaf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .anchor    (anchor_rd),
      .qstat     (qstat),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: sv/uaf_front.sv
// ----------------------------------------------------------------------------
// Anchor finder front
// Accepts words, keeps component positions and the run counter, and hands
// each closed anchor to the queue as a snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uaf_front #(
   parameter int MAX_COMPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  uaf_pkg::uaf_req_type              req_item,
   output logic                              req_full,
   input  logic [uaf_pkg::POS_W-1:0]         min_len,
   input  uaf_pkg::uaf_qstat_type            qstat,
   output logic                              anchor_push,
   output uaf_pkg::uaf_anchor_type           anchor
);
   import uaf_pkg::*;

   localparam int LANES = (MAX_COMPS < LANE_LIMIT) ? MAX_COMPS : LANE_LIMIT;
   localparam logic [COUNT_W-1:0] LANES_CNT = COUNT_W'(LANES);

   logic [LANES-1:0][POS_W-1:0] pos_ff, pos_in, pos_adv;
   logic [POS_W-1:0]            run_ff, run_in, run_inc;
   logic                        accept, is_col, is_load, gap;
   logic [COUNT_W-1:0]          n_clip;
   logic [GAP_W-1:0]            active;
   logic                        qual_old, qual_new;

   assign req_full = qstat.full;
   assign accept   = req_push && !qstat.full;
   assign is_col   = accept && (req_item.op == OP_COLUMN);
   assign is_load  = accept && (req_item.op == OP_LOAD);

   // Active lanes: component count limited to the lanes that exist.
   always_comb begin
      n_clip = (req_item.comp_count > LANES_CNT) ? LANES_CNT : req_item.comp_count;
      for (int i = 0; i < GAP_W; i++) begin
         active[i] = COUNT_W'(i) < n_clip;
      end
      gap = |(req_item.gap_mask & active);
   end

   // Run counter with saturation.
   assign run_inc  = (run_ff == '1) ? run_ff : run_ff + 1'b1;
   assign qual_old = (run_ff != '0) && (run_ff >= min_len);
   assign qual_new = (run_inc != '0) && (run_inc >= min_len);

   always_comb begin
      run_in = run_ff;
      if (is_load) begin
         run_in = '0;
      end else if (is_col) begin
         run_in = gap ? '0 : run_inc;
         if (req_item.last_column) begin
            run_in = '0;
         end
      end
   end

   // Each lane advances when it is active and has no gap in the column.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         pos_adv[i] = (active[i] && !req_item.gap_mask[i]) ? pos_ff[i] + 1'b1 : pos_ff[i];
         pos_in[i]  = pos_ff[i];
         if (is_load && ({1'b0, req_item.comp_index} == COUNT_W'(i))) begin
            pos_in[i] = req_item.start_pos;
         end else if (is_col) begin
            pos_in[i] = pos_adv[i];
         end
      end
   end

   // A gap column reports the old positions; a final gap-free column the advanced ones.
   always_comb begin
      anchor       = '0;
      anchor.count = n_clip;
      anchor.len   = gap ? run_ff : run_inc;
      for (int i = 0; i < LANES; i++) begin
         anchor.pos[i] = gap ? pos_ff[i] : pos_adv[i];
      end
      anchor_push = is_col && (n_clip != '0) &&
                    (gap ? qual_old : (req_item.last_column && qual_new));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

endmodule

FILE: sv/uaf_queue.sv
// ----------------------------------------------------------------------------
// Anchor queue
// Short queue of anchor snapshots between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uaf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  uaf_pkg::uaf_anchor_type wr_data,
   input  logic                    pop,
   output uaf_pkg::uaf_anchor_type rd_data,
   output uaf_pkg::uaf_qstat_type  qstat
);
   import uaf_pkg::*;

   uaf_anchor_type            slot_ff [ANCHOR_DEPTH];
   logic [APTR_W-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [APTR_W:0]           cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == (APTR_W+1)'(ANCHOR_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign rd_data     = slot_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= wr_data;
      end
   end

   // The front never pushes into a full queue, the back never pops an empty one.
   `UAF_ASSERT_SAME(a_no_overflow, clock, reset, push, !qstat.full)
   `UAF_ASSERT_SAME(a_no_underflow, clock, reset, pop, !qstat.empty)

endmodule

FILE: sv/uaf_back.sv
// ----------------------------------------------------------------------------
// Anchor finder back
// Walks the lanes of the oldest anchor and puts one result word per cycle
// into the output register while that register is free or being popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uaf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  uaf_pkg::uaf_anchor_type anchor,
   input  uaf_pkg::uaf_qstat_type  qstat,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output uaf_pkg::uaf_rsp_type    rsp_item
);
   import uaf_pkg::*;

   logic [LANE_W-1:0] lane_ff, lane_in;
   uaf_rsp_type       rsp_ff, rsp_in;
   logic              valid_ff, valid_in;
   logic              step, last_lane;

   assign rsp_empty = !valid_ff;
   assign rsp_item  = rsp_ff;

   // A new word moves into the output register when it is free or being taken.
   assign step      = !qstat.empty && (!valid_ff || rsp_pop);
   assign last_lane = (({1'b0, lane_ff} + 1'b1) == anchor.count);
   assign q_pop     = step && last_lane;

   always_comb begin
      lane_in  = lane_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (step) begin
         rsp_in.anchor_comp  = lane_ff;
         rsp_in.anchor_start = anchor.pos[lane_ff] - anchor.len;
         rsp_in.anchor_len   = anchor.len;
         rsp_in.last         = last_lane;
         valid_in            = 1'b1;
         lane_in             = last_lane ? '0 : lane_ff + 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         lane_ff  <= lane_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // After the last lane of an anchor the walk starts again at lane zero,
   // and the word just loaded is marked last.
   `UAF_ASSERT_NEXT(a_lane_restart, clock, reset, q_pop, (lane_ff == '0) && rsp_ff.last)

endmodule

FILE: test/tb_ungapped_anchor_finder_core.sv
// ----------------------------------------------------------------------------
// Ungapped anchor finder core testbench
// Drives load and column words through the push side and checks every anchor
// word on the pop side against an in-bench prediction of positions and run
// length. The minimum run length goes through several values on the register
// port, including both extremes, and is read back after each write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ungapped_anchor_finder_core;
   import uaf_pkg::*;

   localparam int MAX_LANES      = 16;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 16;

   localparam logic [2:0] ADDR_MIN_LEN = 3'd0;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   uaf_req_type req_item;
   logic        empty;
   logic        pop;
   uaf_rsp_type rsp_item;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Predicted block state.
   logic [POS_W-1:0] lane_pos [MAX_LANES];
   logic [POS_W-1:0] run_cols;
   logic [POS_W-1:0] min_run;

   // Anchor words that are predicted and not yet popped.
   uaf_rsp_type anchor_words_q[$];

   int fail_count;
   int words_sent;
   int idle_cycles;
   bit req_steady;
   bit rsp_steady;

   ungapped_anchor_finder_core #(
      .MAX_COMPS(MAX_LANES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_item(req_item),
      .empty   (empty),
      .pop     (pop),
      .rsp_item(rsp_item),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit run_is_anchor();
      logic [POS_W-1:0] thr;
      thr = (min_run == '0) ? 32'd1 : min_run;
      return run_cols >= thr;
   endfunction

   task automatic report_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
   endtask

   // One anchor gives a word for each active lane.
   task automatic queue_anchor(input int n);
      uaf_rsp_type a;
      for (int i = 0; i < n; i++) begin
         a.anchor_comp  = LANE_W'(i);
         a.anchor_start = lane_pos[i] - run_cols;
         a.anchor_len   = run_cols;
         a.last         = (i == n - 1);
         anchor_words_q.push_back(a);
      end
   endtask

   // Update the predicted state for one accepted word and queue its anchors.
   task automatic predict_anchors(input uaf_req_type w);
      int          n;
      logic [16:0] active;
      bit          gap;
      if (w.op == OP_LOAD) begin
         lane_pos[w.comp_index] = w.start_pos;
         run_cols = '0;
         return;
      end
      n = int'(w.comp_count);
      if (n > MAX_LANES) n = MAX_LANES;
      active = (17'd1 << n) - 17'd1;
      gap = (w.gap_mask & active[15:0]) != '0;
      // A gap column reports before positions move.
      if (!gap) begin
         if (run_cols != '1) run_cols++;
      end else begin
         if (run_is_anchor()) queue_anchor(n);
         run_cols = '0;
      end
      for (int i = 0; i < n; i++) begin
         if (!w.gap_mask[i]) lane_pos[i] += 1;
      end
      // A final gap-free column reports after positions move.
      if (w.last_column) begin
         if (!gap && run_is_anchor()) queue_anchor(n);
         run_cols = '0;
      end
   endtask

   // Send one word; push stays high when the next word follows with no gap.
   task automatic send_word(input uaf_req_type w);
      int gap_len;
      gap_len = req_steady ? 0 : pick_gap();
      if (gap_len > 0) begin
         push <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= w;
      do @(posedge clock); while (full);
      predict_anchors(w);
      words_sent++;
   endtask

   // Hold the sender until every predicted word has come out.
   task automatic drain();
      push <= 1'b0;
      while (anchor_words_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register port transfer: setup cycle, then access until ready.
   task automatic csr_cycle(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_MIN_LEN;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_min_run();
      logic [31:0] rd;
      csr_cycle(1'b0, '0, rd);
      if (rd !== min_run) report_field("min_len readback", min_run, rd);
   endtask

   task automatic set_min_run(input logic [31:0] v);
      logic [31:0] rd;
      csr_cycle(1'b1, v, rd);
      min_run = v;
      check_min_run();
   endtask

   function automatic uaf_req_type load_word(input int lane, input logic [31:0] pos);
      uaf_req_type w;
      w             = '0;
      w.op          = OP_LOAD;
      w.comp_index  = LANE_W'(lane);
      w.start_pos   = pos;
      w.comp_count  = COUNT_W'($urandom);
      w.gap_mask    = GAP_W'($urandom);
      w.last_column = 1'($urandom);
      return w;
   endfunction

   function automatic uaf_req_type column_word(input int count, input logic [15:0] mask,
                                               input bit last_col);
      uaf_req_type w;
      w             = '0;
      w.op          = OP_COLUMN;
      w.comp_index  = LANE_W'($urandom);
      w.start_pos   = $urandom;
      w.comp_count  = COUNT_W'(count);
      w.gap_mask    = mask;
      w.last_column = last_col;
      return w;
   endfunction

   // Reset value on the register port, then both extremes.
   task automatic test_register_port();
      check_min_run();
      set_min_run(32'hFFFF_FFFF);
      set_min_run(32'd0);
   endtask

   // Load every lane, with positions at both ends of the range.
   task automatic test_load_positions();
      logic [31:0] pos;
      for (int i = 0; i < MAX_LANES; i++) begin
         case (i)
            0:       pos = 32'h0000_0000;
            1:       pos = 32'hFFFF_FFFF;
            2:       pos = 32'hFFFF_FFFE;
            3:       pos = 32'h8000_0000;
            default: pos = $urandom;
         endcase
         send_word(load_word(i, pos));
      end
   endtask

   // Zero minimum acts as one; clamped, tiny and empty counts; load clears the run.
   task automatic test_clamped_columns();
      send_word(column_word(31, 16'h0000, 1'b0));
      send_word(column_word(31, 16'h8000, 1'b0));
      send_word(column_word(1, 16'hFFFE, 1'b1));
      send_word(column_word(0, 16'hFFFF, 1'b1));
      send_word(column_word(2, 16'h0001, 1'b0));
      send_word(column_word(16, 16'h0000, 1'b0));
      send_word(load_word(5, 32'h0000_1000));
      send_word(column_word(16, 16'h0020, 1'b0));
      drain();
   endtask

   // The largest minimum never lets a run count.
   task automatic test_threshold_extremes();
      set_min_run(32'hFFFF_FFFF);
      send_word(column_word(2, 16'h0000, 1'b0));
      send_word(column_word(2, 16'h0000, 1'b1));
      drain();
   endtask

   // One alignment block: some loads, then columns closed by a final column.
   task automatic send_random_block();
      int          r;
      int          n_field;
      int          n_act;
      int          ncols;
      logic [15:0] act;
      logic [15:0] m;
      logic [31:0] pos;
      uaf_req_type w;
      r = $urandom_range(0, 9);
      if (r < 8)      n_field = $urandom_range(2, 16);
      else if (r < 9) n_field = $urandom_range(17, 31);
      else            n_field = $urandom_range(0, 1);
      n_act = (n_field > MAX_LANES) ? MAX_LANES : n_field;
      act = 16'((17'd1 << n_act) - 17'd1);
      for (int i = 0; i < n_act; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            pos = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                              : $urandom;
            send_word(load_word(i, pos));
         end
      end
      ncols = $urandom_range(1, 12);
      for (int c = 0; c < ncols; c++) begin
         if ($urandom_range(0, 19) == 0) begin
            // Noise: any word at all.
            w = ($urandom_range(0, 1) == 0) ? load_word($urandom_range(0, 15), $urandom)
                : column_word($urandom_range(0, 31), 16'($urandom), 1'($urandom));
         end else begin
            if ($urandom_range(0, 99) < 15 && act != '0) begin
               m = 16'($urandom) & act;
               if (m == '0) m = act & (16'd1 << $urandom_range(0, n_act - 1));
               m = m | (16'($urandom) & ~act);
            end else begin
               m = 16'($urandom) & ~act;
            end
            w = column_word(n_field, m, c == ncols - 1);
         end
         send_word(w);
      end
   endtask

   task automatic test_random_blocks(input logic [31:0] min_v, input bit steady,
                                     input bit pause_mid);
      int first;
      set_min_run(min_v);
      req_steady = steady;
      rsp_steady = steady;
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) begin
         send_random_block();
         // Let the queue empty out once partway through.
         if (pause_mid && words_sent - first >= PHASE_WORDS / 2) begin
            drain();
            pause_mid = 0;
         end
      end
      drain();
      req_steady = 0;
      rsp_steady = 0;
   endtask

   // Pop side: bursts of pops separated by random stalls.
   initial begin
      int hold;
      hold = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_steady) begin
            pop <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else if (pop) begin
            hold = pick_gap();
            if (hold > 0) begin
               pop <= 1'b0;
               hold--;
            end
         end else begin
            pop <= 1'b1;
            hold = $urandom_range(0, 7);
         end
      end
   end

   // Compare each popped word with the oldest prediction.
   always @(posedge clock) begin
      uaf_rsp_type exp_w;
      if (!reset && pop && !empty) begin
         if (anchor_words_q.size() == 0) begin
            $display("%0t: unexpected anchor word, expected none, actual %h",
                     $time, rsp_item);
            fail_count++;
         end else begin
            exp_w = anchor_words_q.pop_front();
            if (rsp_item.anchor_comp !== exp_w.anchor_comp)
               report_field("anchor_comp", 32'(exp_w.anchor_comp),
                            32'(rsp_item.anchor_comp));
            if (rsp_item.anchor_start !== exp_w.anchor_start)
               report_field("anchor_start", exp_w.anchor_start, rsp_item.anchor_start);
            if (rsp_item.anchor_len !== exp_w.anchor_len)
               report_field("anchor_len", exp_w.anchor_len, rsp_item.anchor_len);
            if (rsp_item.last !== exp_w.last)
               report_field("last", 32'(exp_w.last), 32'(rsp_item.last));
         end
      end
   end

   // Watchdog: too many cycles in a row with no transfer anywhere.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      fail_count  = 0;
      words_sent  = 0;
      idle_cycles = 0;
      req_steady  = 0;
      rsp_steady  = 0;
      run_cols    = '0;
      min_run     = MIN_LEN_RESET;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_item <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_port();
      test_load_positions();
      test_clamped_columns();
      test_threshold_extremes();
      test_random_blocks(32'd1, 1'b0, 1'b0);
      test_random_blocks(32'd3, 1'b1, 1'b0);
      test_random_blocks(32'($urandom_range(2, 8)), 1'b0, 1'b1);
      test_random_blocks(32'd4, 1'b0, 1'b0);

      drain();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/uaf_pkg.sv
sv/uaf_front.sv
sv/uaf_queue.sv
sv/uaf_back.sv
sv/ungapped_anchor_finder_core.sv
test/tb_ungapped_anchor_finder_core.sv
